FILE: rtl/core/dzsf_pkg.sv
`default_nettype none

package dzsf_pkg;

	typedef struct packed {
		logic signed [15:0] camera_x;
		logic signed [15:0] camera_y;
	} cam_word_t;

	typedef struct packed {
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
	} ofs_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TGT_X,
		ST_TGT_Y,
		ST_PREP,
		ST_DIV,
		ST_UPD,
		ST_DONE
	} fsm_state_t;

	localparam logic [2:0] REG_VIEW_X   = 3'd0;
	localparam logic [2:0] REG_VIEW_Y   = 3'd1;
	localparam logic [2:0] REG_DZONE_X  = 3'd2;
	localparam logic [2:0] REG_DZONE_Y  = 3'd3;
	localparam logic [2:0] REG_MAP_SIZE = 3'd4;
	localparam logic [2:0] REG_MODE     = 3'd5;
	localparam logic [2:0] REG_EASING   = 3'd6;
	localparam logic [2:0] REG_ACTIVE   = 3'd7;

	// scroll modes that repeat on one axis and so skip its clamp
	localparam logic [1:0] MODE_HREP = 2'd1;
	localparam logic [1:0] MODE_VREP = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/deadzone_scroll_follow_unit.sv
// Each word runs through ST_TGT_X, ST_TGT_Y, ST_PREP, ST_DIV, ST_UPD and ST_DONE with easing above 1,
// skips ST_PREP and ST_DIV with easing 0 or 1, and goes straight to ST_DONE with follow inactive.
// A new word is accepted only in ST_IDLE, once the last one is through. The shift-and-subtract
// divider makes one quotient bit per cycle for both axes.
// A result waiting at the output holds the sequencer in ST_DONE and so blocks the next word.
// Reset (arst_n low, async): offsets and targets 0, registers 0, follow_active 1.
`default_nettype none

module deadzone_scroll_follow_unit #(
	parameter int COORD_BITS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  dzsf_pkg::cam_word_t    in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output dzsf_pkg::ofs_word_t    out_data,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [2:0]             cfg_index,
	input  wire  [31:0]            cfg_data
);
	import dzsf_pkg::*;

	localparam int N  = COORD_BITS;
	localparam int SW = ((N > 16) ? N : 16) + 1;
	localparam int TW = (N > 20) ? N : 20;
	localparam int CW = $clog2(N + 2);

	// configuration
	logic [31:0] view_x_q, view_y_q, dz_x_q, dz_y_q, map_size_q;
	logic [1:0]  mode_q;
	logic [7:0]  easing_q;
	logic        active_q;

	fsm_state_t state_q, state_d;

	cam_word_t in_s1;
	ofs_word_t out_q;
	logic      out_valid_q;

	logic signed [N-1:0] cur_q [2];
	logic signed [N-1:0] tgt_q [2];
	logic [N:0]          quo_q [2];
	logic [7:0]          rem_q [2];
	logic                neg_q [2];
	logic [CW-1:0]       cnt_q;

	logic ld_in, tgt_we, div_load, div_step, cur_we, out_load;
	logic jump;

	assign cfg_ready = 1'b1;
	assign jump      = (easing_q <= 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q   <= '0;
			view_y_q   <= '0;
			dz_x_q     <= '0;
			dz_y_q     <= '0;
			map_size_q <= '0;
			mode_q     <= '0;
			easing_q   <= '0;
			active_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VIEW_X:   view_x_q   <= cfg_data;
				REG_VIEW_Y:   view_y_q   <= cfg_data;
				REG_DZONE_X:  dz_x_q     <= cfg_data;
				REG_DZONE_Y:  dz_y_q     <= cfg_data;
				REG_MAP_SIZE: map_size_q <= cfg_data;
				REG_MODE:     mode_q     <= cfg_data[1:0];
				REG_EASING:   easing_q   <= cfg_data[7:0];
				REG_ACTIVE:   active_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = active_q ? ST_TGT_X : ST_DONE;
			ST_TGT_X: state_d = ST_TGT_Y;
			ST_TGT_Y: state_d = jump ? ST_UPD : ST_PREP;
			ST_PREP:  state_d = ST_DIV;
			ST_DIV:   if (cnt_q == '0) state_d = ST_UPD;
			ST_UPD:   state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		tgt_we   = 1'b0;
		div_load = 1'b0;
		div_step = 1'b0;
		cur_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_TGT_X: tgt_we   = 1'b1;
			ST_TGT_Y: tgt_we   = 1'b1;
			ST_PREP:  div_load = 1'b1;
			ST_DIV:   div_step = 1'b1;
			ST_UPD:   cur_we   = 1'b1;
			ST_DONE:  out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign ld_in = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (ld_in) begin
			in_s1 <= in_data;
		end
	end

	// target unit, shared by the two axes: x in ST_TGT_X, y in ST_TGT_Y
	logic                ax;
	logic signed [15:0]  pos, v0, v1, d0, d1;
	logic [31:0]         view_sel, dz_sel;
	logic [15:0]         map_ext, span;
	logic                clamp;
	logic signed [N-1:0] cur_sel;
	logic signed [17:0]  room;
	logic signed [19:0]  t_r, t_l, t_sel;
	logic                cl_r, cl_l, hit_r, hit_l;
	logic signed [SW-1:0] sum;
	logic signed [TW-1:0] t_ext;

	always_comb begin
		ax       = (state_q == ST_TGT_Y);
		pos      = ax ? $signed(in_s1.camera_y) : $signed(in_s1.camera_x);
		view_sel = ax ? view_y_q : view_x_q;
		dz_sel   = ax ? dz_y_q : dz_x_q;
		map_ext  = ax ? map_size_q[31:16] : map_size_q[15:0];
		clamp    = ax ? (mode_q != MODE_VREP) : (mode_q != MODE_HREP);
		cur_sel  = cur_q[ax];
		v0       = $signed(view_sel[15:0]);
		v1       = $signed(view_sel[31:16]);
		d0       = $signed(dz_sel[15:0]);
		d1       = $signed(dz_sel[31:16]);
		span     = v1 - v0;
		room     = $signed({2'b00, map_ext}) - $signed({2'b00, span});
		t_r      = 20'(d1) - 20'(pos);
		t_l      = 20'(d0) - 20'(pos);
		cl_r     = clamp && ((t_r - 20'(v0)) < -20'(room));
		cl_l     = clamp && ((t_l - 20'(v0)) > 20'sd0);
		sum      = SW'(cur_sel) + SW'(pos);
		hit_r    = sum > SW'(d1);
		hit_l    = sum < SW'(d0);
		// inverted window: left/top edge wins
		if (hit_l) begin
			t_sel = cl_l ? 20'(v0) : t_l;
		end else begin
			t_sel = cl_r ? (20'(v0) - 20'(room)) : t_r;
		end
		t_ext = TW'(t_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q[0] <= '0;
			tgt_q[1] <= '0;
		end else if (tgt_we && (hit_l || hit_r)) begin
			tgt_q[ax] <= t_ext[N-1:0];
		end
	end

	// step counter for the divider, N+1 quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (div_load) begin
			cnt_q <= CW'(N);
		end else if (div_step) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// per-axis lane: serial restoring divide of |target - cur| by easing, then update
	for (genvar a = 0; a < 2; a++) begin : g_lane
		logic signed [N:0]   diff;
		logic [N:0]          mag;
		logic [8:0]          rem_sh;
		logic                ge;
		logic signed [N+1:0] sq;
		logic signed [N+1:0] upd;

		always_comb begin
			diff   = (N+1)'(tgt_q[a]) - (N+1)'(cur_q[a]);
			mag    = diff[N] ? (N+1)'(-diff) : diff;
			rem_sh = {rem_q[a], quo_q[a][N]};
			ge     = (rem_sh >= {1'b0, easing_q});
			sq     = neg_q[a] ? -$signed({1'b0, quo_q[a]}) : $signed({1'b0, quo_q[a]});
			upd    = (N+2)'(cur_q[a]) + sq;
		end

		always_ff @(posedge clk) begin
			if (div_load) begin
				quo_q[a] <= mag;
				rem_q[a] <= '0;
				neg_q[a] <= diff[N];
			end else if (div_step) begin
				quo_q[a] <= {quo_q[a][N-1:0], ge};
				rem_q[a] <= ge ? 8'(rem_sh - {1'b0, easing_q}) : rem_sh[7:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cur_q[a] <= '0;
			end else if (cur_we) begin
				cur_q[a] <= jump ? tgt_q[a] : upd[N-1:0];
			end
		end
	end

	// output word register
	logic signed [31:0] ox_ext, oy_ext;

	assign ox_ext = 32'(cur_q[0]);
	assign oy_ext = 32'(cur_q[1]);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.offset_x <= ox_ext[15:0];
			out_q.offset_y <= oy_ext[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ld_in |=> state_q != ST_IDLE)
		else $error("word accepted but sequencer stayed idle");

	a_div_needs_easing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> easing_q > 8'd1)
		else $error("divider running with jump easing");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= CW'(N))
		else $error("divider step count out of range");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("output word loaded outside completion");

endmodule

`default_nettype wire

FILE: dv/scroll_offset_checker.sv
module scroll_offset_checker #(
	parameter int COORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  dzsf_pkg::cam_word_t in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  dzsf_pkg::ofs_word_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output int                  errors,
	output int                  pending
);
	import dzsf_pkg::*;

	logic [31:0] view_x = '0;
	logic [31:0] view_y = '0;
	logic [31:0] zone_x = '0;
	logic [31:0] zone_y = '0;
	logic [31:0] map_dims = '0;
	logic [1:0]  mode = '0;
	logic [7:0]  easing = '0;
	logic        active = 1'b1;
	longint      ofs_x = 0;
	longint      ofs_y = 0;
	longint      goal_x = 0;
	longint      goal_y = 0;
	ofs_word_t   offset_queue[$];
	ofs_word_t   want;

	function automatic longint fold_to_coord(input longint v);
		longint m;
		longint u;
		m = longint'(1) << COORD_BITS;
		u = v & (m - 1);
		return (u >= (m >> 1)) ? u - m : u;
	endfunction

	// One axis: pull the goal so the position sits on the crossed dead-zone edge,
	// then keep the view inside the map unless this axis repeats.
	function automatic longint chase_edge(input longint pos, input logic [31:0] view,
			input logic [31:0] zone, input longint extent, input bit clamp,
			input longint ofs, input longint goal);
		longint v0, v1, d0, d1, span, room, t;
		v0 = longint'($signed(view[15:0]));
		v1 = longint'($signed(view[31:16]));
		d0 = longint'($signed(zone[15:0]));
		d1 = longint'($signed(zone[31:16]));
		span = (v1 - v0) & 64'hFFFF;
		room = extent - span;
		if (ofs + pos > d1) begin
			t = d1 - pos;
			if (clamp && (t - v0) < -room)
				t = v0 - room;
			goal = fold_to_coord(t);
		end
		// left/top edge is tested second so it wins on an inverted window
		if (ofs + pos < d0) begin
			t = d0 - pos;
			if (clamp && (t - v0) > 0)
				t = v0;
			goal = fold_to_coord(t);
		end
		return goal;
	endfunction

	task automatic take_position(input cam_word_t w);
		longint px, py;
		ofs_word_t fresh;
		if (active) begin
			px = longint'($signed(w.camera_x));
			py = longint'($signed(w.camera_y));
			goal_x = chase_edge(px, view_x, zone_x, longint'(map_dims[15:0]),
				mode != MODE_HREP, ofs_x, goal_x);
			goal_y = chase_edge(py, view_y, zone_y, longint'(map_dims[31:16]),
				mode != MODE_VREP, ofs_y, goal_y);
			if (easing <= 8'd1) begin
				ofs_x = goal_x;
				ofs_y = goal_y;
			end else begin
				ofs_x = fold_to_coord(ofs_x + (goal_x - ofs_x) / longint'(easing));
				ofs_y = fold_to_coord(ofs_y + (goal_y - ofs_y) / longint'(easing));
			end
		end
		fresh.offset_x = ofs_x[15:0];
		fresh.offset_y = ofs_y[15:0];
		offset_queue.push_back(fresh);
	endtask

	task automatic report(input string msg);
		errors++;
		if (errors <= 40)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x = '0;
			view_y = '0;
			zone_x = '0;
			zone_y = '0;
			map_dims = '0;
			mode = '0;
			easing = '0;
			active = 1'b1;
			ofs_x = 0;
			ofs_y = 0;
			goal_x = 0;
			goal_y = 0;
			offset_queue.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VIEW_X:   view_x = cfg_data;
					REG_VIEW_Y:   view_y = cfg_data;
					REG_DZONE_X:  zone_x = cfg_data;
					REG_DZONE_Y:  zone_y = cfg_data;
					REG_MAP_SIZE: map_dims = cfg_data;
					REG_MODE:     mode = cfg_data[1:0];
					REG_EASING:   easing = cfg_data[7:0];
					REG_ACTIVE:   active = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_position(in_data);
			if (out_valid && out_ready) begin
				if (offset_queue.size() == 0) begin
					report($sformatf("offset word %h with nothing expected", out_data));
				end else begin
					want = offset_queue.pop_front();
					if (out_data.offset_x !== want.offset_x)
						report($sformatf("offset_x got %0d want %0d",
							$signed(out_data.offset_x), $signed(want.offset_x)));
					if (out_data.offset_y !== want.offset_y)
						report($sformatf("offset_y got %0d want %0d",
							$signed(out_data.offset_y), $signed(want.offset_y)));
				end
			end
			pending = offset_queue.size();
		end
	end

endmodule

FILE: dv/testbench.sv
module testbench;
	import dzsf_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_BOTH = 2'd3;
	localparam int HOLD_CYCLES  = 300;
	localparam int WATCH_LIMIT  = 3000;
	localparam int RANDOM_ITEMS = 650;
	localparam int DRAIN_CYCLES = 30;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	cam_word_t   in_data;
	logic        out_valid;
	logic        out_ready;
	ofs_word_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;
	bit          calm;
	bit          hold_req;

	deadzone_scroll_follow_unit dut (.*);

	scroll_offset_checker chk (.*);

	always #6 clk = ~clk;

	task automatic send_pos(input logic [15:0] x, input logic [15:0] y);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{camera_x: x, camera_y: y};
		do @(posedge clk); while (!in_ready);
	endtask

	// leaves cfg_valid high so back-to-back writes run without dropping it between them
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_all(input logic [31:0] vx, input logic [31:0] vy,
			input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dims,
			input logic [31:0] md, input logic [31:0] ease, input logic [31:0] act);
		write_reg(REG_VIEW_X, vx);
		write_reg(REG_VIEW_Y, vy);
		write_reg(REG_DZONE_X, dx);
		write_reg(REG_DZONE_Y, dy);
		write_reg(REG_MAP_SIZE, dims);
		write_reg(REG_MODE, md);
		write_reg(REG_EASING, ease);
		write_reg(REG_ACTIVE, act);
		cfg_valid <= 1'b0;
	endtask

	// wait for every expected offset word so registers change only while idle
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [31:0] edge_pair();
		logic [15:0] lo, hi;
		case ($urandom_range(0, 7))
			0: begin
				lo = 16'($urandom());
				hi = 16'($urandom());
			end
			1: begin
				lo = 16'h7FFF;
				hi = 16'h8000;
			end
			2: begin
				lo = 16'h8000;
				hi = 16'h7FFF;
			end
			3: begin
				hi = 16'($urandom_range(0, 300));
				lo = hi + 16'($urandom_range(1, 200));
			end
			default: begin
				lo = 16'($urandom_range(0, 300));
				hi = lo + 16'($urandom_range(0, 400));
			end
		endcase
		return {hi, lo};
	endfunction

	function automatic logic [31:0] pick_map();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'hFFFF_FFFF;
			2: return 32'h0;
			default: return {16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048))};
		endcase
	endfunction

	function automatic logic [7:0] pick_easing();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			3: return 8'($urandom());
			default: return 8'($urandom_range(2, 8));
		endcase
	endfunction

	// upper bits of the narrow registers are random to show they are dropped
	function automatic logic [31:0] pick_reg(input logic [2:0] idx);
		case (idx)
			REG_VIEW_X, REG_VIEW_Y, REG_DZONE_X, REG_DZONE_Y: return edge_pair();
			REG_MAP_SIZE: return pick_map();
			REG_MODE:     return $urandom();
			REG_EASING:   return {24'($urandom()), pick_easing()};
			default:      return {31'($urandom()), 1'($urandom_range(0, 5) != 0)};
		endcase
	endfunction

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				// long back-pressure so the block fills and stalls its input
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCH_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int sent;
		int count;
		int phase;
		bit wrote;
		logic [15:0] px, py;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_VIEW_X;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults, field extremes
		send_pos(16'h7FFF, 16'h8000);
		send_pos(16'h8000, 16'h7FFF);
		send_pos(16'h0000, 16'h0000);
		send_pos(16'hFFFF, 16'h0001);

		settle();
		load_all({16'd320, 16'd0}, {16'd240, 16'd0}, {16'd220, 16'd100}, {16'd160, 16'd80},
			{16'd512, 16'd1024}, {30'd0, MODE_NONE}, 32'd0, 32'd1);
		send_pos(16'd500, 16'd300);
		send_pos(16'd150, 16'd120);
		send_pos(16'd2000, 16'd2000);
		send_pos(-16'sd500, -16'sd500);
		send_pos(16'd5, 16'd5);

		// horizontal repeat and easing 4, both from words with junk in the upper bits
		settle();
		load_all({16'd320, 16'd0}, {16'd240, 16'd0}, {16'd220, 16'd100}, {16'd160, 16'd80},
			{16'd300, 16'd640}, {30'h3FFF_FFFF, MODE_HREP}, 32'hABCD_0104, 32'd1);
		send_pos(16'd900, 16'd40);
		send_pos(16'd900, 16'd40);
		send_pos(-16'sd300, 16'd700);

		// view width wraps, dead zone inverted on x, vertical repeat, easing 1
		settle();
		load_all({16'd100, 16'd300}, {16'hFF00, 16'd10}, {16'd50, 16'd200}, {16'd10, 16'd90},
			{16'd200, 16'd0}, {30'h2AAA_AAAA, MODE_VREP}, 32'd1, 32'd1);
		send_pos(16'd125, 16'd50);
		send_pos(16'd0, 16'd0);
		send_pos(-16'sd20, 16'd400);

		// full-range windows and map: sums and clamps past 16 bits
		settle();
		load_all({16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF}, {16'h7FFF, 16'h8000},
			{16'h0000, 16'h0000}, 32'hFFFF_FFFF, {30'd0, MODE_BOTH}, 32'd255, 32'd1);
		send_pos(16'h7FFF, 16'h7FFF);
		send_pos(16'h8000, 16'h8000);
		send_pos(16'h7FFF, 16'h8000);
		send_pos(16'h0000, 16'h0000);

		// follow off: offsets held
		settle();
		write_reg(REG_ACTIVE, {31'h7FFF_FFFF, 1'b0});
		cfg_valid <= 1'b0;
		send_pos(16'd1234, -16'sd1234);
		send_pos(16'h7FFF, 16'h0000);

		sent = 0;
		phase = 0;
		px = 16'd160;
		py = 16'd120;
		while (sent < RANDOM_ITEMS) begin
			settle();
			wrote = 1'b0;
			for (int i = REG_VIEW_X; i <= REG_ACTIVE; i++) begin
				if ($urandom_range(0, 1)) begin
					write_reg(3'(i), pick_reg(3'(i)));
					wrote = 1'b1;
				end
			end
			if (wrote)
				cfg_valid <= 1'b0;
			calm = ($urandom_range(0, 3) == 0);
			count = $urandom_range(10, 40);
			if (phase == 1) begin
				calm = 1'b1;
				hold_req = 1'b1;
				count = 16;
			end
			repeat (count) begin
				// mostly a smooth track, now and then a jump anywhere
				if ($urandom_range(0, 7) == 0) begin
					px = 16'($urandom());
					py = 16'($urandom());
				end else begin
					px = px + 16'($urandom_range(0, 128)) - 16'd64;
					py = py + 16'($urandom_range(0, 128)) - 16'd64;
				end
				send_pos(px, py);
				sent++;
			end
			phase++;
		end

		settle();
		calm = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/dzsf_pkg.sv
rtl/core/deadzone_scroll_follow_unit.sv
dv/scroll_offset_checker.sv
dv/testbench.sv
